/* rtl/core/kbi_pkg.sv */
package kbi_pkg;

  // One keyframe as it sits in the key memory.
  typedef struct packed {
    logic [31:0] time_v;
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [31:0] orient;
  } key_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_INTERP = 2'd0;
  localparam logic [1:0] STAT_BEFORE = 2'd1;
  localparam logic [1:0] STAT_AFTER  = 2'd2;

  localparam logic [7:0] REG_KEY_COUNT   = 8'd0;
  localparam logic [7:0] REG_INTERP_MODE = 8'd1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_CUBIC  = 2'd1;

  localparam logic [6:0] KEY_COUNT_RESET = 7'd1;

endpackage

/* rtl/core/kbi_divider.sv */
module kbi_divider #(
  parameter int NUM_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [31:0]      divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [31:0]      rem_q;
  logic [31:0]      den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [32:0]      shifted;
  logic             ge;
  logic [32:0]      diff;

  // Restoring division, one quotient bit per cycle. Quotient bits shift
  // into the dividend register as its bits shift out.
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[31:0] : shifted[31:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

/* rtl/core/keyframe_bezier_interpolator.sv */
// Keyframe interpolator. Keys are written into an internal table with write
// requests (operation 0) and read back blended with query requests
// (operation 1). Both channels use valid/stall; a request is taken when
// in_valid_i is high and in_stall_o is low, a result when out_valid_o is
// high and out_stall_i is low. The config channel (cfg_valid_i/cfg_ready_o)
// sets key_count (index 0) and interp_mode (index 1) and is always ready.
// A write request gives no result and leaves the input free for the next
// request. A query reads key 0 and the last key; a clamped query then goes
// straight to the result. Otherwise the key table is scanned one entry per
// cycle, the serial divider runs and the shared multiplier takes seven steps,
// so an interpolated query's time is set mostly by the one-bit-per-cycle
// divider and the single memory read port.
// in_stall_o is high while a query is in flight.
// The result sits in an output register; a stalled receiver holds it, and
// the next request is accepted meanwhile, but a finished query waits for
// that register to free. Reset sets key_count 1 and interp_mode 1; key
// contents are undefined until written.
module keyframe_bezier_interpolator #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [5:0]  key_slot_i,
  input  logic [31:0] sample_time_i,
  input  logic [31:0] key_pos_a_i,
  input  logic [31:0] key_pos_b_i,
  input  logic [31:0] key_orient_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pos_a_o,
  output logic [31:0] pos_b_o,
  output logic [31:0] orientation_o,
  output logic [1:0]  clamp_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int F     = FRAC_BITS;
  localparam int NUM_W = 32 + F;
  localparam int PW    = 35 + F;
  localparam int WW    = F + 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [6:0]  key_count_q;
  logic [1:0]  interp_mode_q;

  kbi_pkg::key_t mem_q [MAX_KEYS];
  kbi_pkg::key_t rd_data_q;
  kbi_pkg::key_t wr_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [31:0]   t_q;
  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] idx_q;
  kbi_pkg::key_t lo_q, hi_q;
  logic [F:0]    alpha_q, sq_q, wo_q, cu, wp, mul_w;
  logic [2:0]    step_q;
  logic signed [PW-1:0] prod_q, prod, shr;
  logic signed [32:0]   ma;
  logic signed [WW-1:0] w_raw;
  logic [31:0]   res_a_q, res_b_q, res_o_q;
  logic [1:0]    status_q;
  logic          dz_q;
  logic          accept, advance;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quot;
  logic [31:0]      div_den;

  logic        out_valid_q;
  logic [31:0] pos_a_q, pos_b_q, orient_q;
  logic [1:0]  clamp_q;
  logic        out_free;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mem_we  = accept && operation_i == kbi_pkg::OP_WRITE
                   && 32'(key_slot_i) < 32'(MAX_KEYS);
  assign wr_data = '{time_v: sample_time_i, pos_a: key_pos_a_i,
                     pos_b: key_pos_b_i, orient: key_orient_i};

  assign advance = idx_q < last_q && !(t_q < rd_data_q.time_v);

  always_comb begin
    case (state_q)
      S_FIRST:  rd_addr = last_q;
      S_LAST:   rd_addr = AW'(1);
      S_SEARCH: rd_addr = idx_q + AW'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(key_slot_i)] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Key count 0 acts as one key, counts above the table size as a full table.
  always_comb begin
    if (key_count_q == 7'd0) begin
      last_d = '0;
    end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
      last_d = AW'(MAX_KEYS - 1);
    end else begin
      last_d = AW'(key_count_q - 7'd1);
    end
  end

  assign div_start = state_q == S_SEARCH && !advance;
  assign div_den   = rd_data_q.time_v - lo_q.time_v;

  kbi_divider #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({t_q - lo_q.time_v, F'(0)}),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // Shared multiplier: the operands follow the step counter.
  assign shr = prod_q >>> F;
  assign cu  = shr[F:0];
  assign wp  = (interp_mode_q == kbi_pkg::MODE_LINEAR) ? alpha_q : wo_q;

  always_comb begin
    case (step_q)
      3'd0: begin
        ma    = $signed(33'(alpha_q));
        mul_w = alpha_q;
      end
      3'd1: begin
        ma    = $signed(33'(shr[F:0]));
        mul_w = alpha_q;
      end
      3'd3: begin
        ma    = $signed({hi_q.pos_a[31], hi_q.pos_a}) - $signed({lo_q.pos_a[31], lo_q.pos_a});
        mul_w = wp;
      end
      3'd4: begin
        ma    = $signed({hi_q.pos_b[31], hi_q.pos_b}) - $signed({lo_q.pos_b[31], lo_q.pos_b});
        mul_w = wp;
      end
      3'd5: begin
        ma    = $signed({hi_q.orient[31], hi_q.orient})
                - $signed({lo_q.orient[31], lo_q.orient});
        mul_w = wo_q;
      end
      default: begin
        ma    = '0;
        mul_w = '0;
      end
    endcase
  end

  assign prod  = PW'(ma * $signed({1'b0, mul_w}));
  assign w_raw = $signed(WW'(sq_q)) + $signed(WW'({sq_q, 1'b0}))
                 - $signed(WW'({cu, 1'b0}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept && operation_i == kbi_pkg::OP_QUERY) state_d = S_FIRST;
      S_FIRST:  state_d = S_LAST;
      S_LAST: begin
        if (t_q < lo_q.time_v || !(t_q < rd_data_q.time_v)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: if (!advance) state_d = S_DIV;
      S_DIV:    if (div_done) state_d = S_MUL;
      S_MUL:    if (step_q == 3'd6) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      key_count_q   <= kbi_pkg::KEY_COUNT_RESET;
      interp_mode_q <= kbi_pkg::MODE_CUBIC;
      out_valid_q   <= 1'b0;
      step_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == kbi_pkg::REG_KEY_COUNT) begin
          key_count_q <= cfg_data_i[6:0];
        end else if (cfg_index_i == kbi_pkg::REG_INTERP_MODE) begin
          interp_mode_q <= cfg_data_i[1:0];
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_MUL) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q    <= sample_time_i;
      last_q <= last_d;
    end
    case (state_q)
      S_FIRST: lo_q <= rd_data_q;
      S_LAST: begin
        idx_q <= AW'(1);
        if (t_q < lo_q.time_v) begin
          res_a_q  <= lo_q.pos_a;
          res_b_q  <= lo_q.pos_b;
          res_o_q  <= lo_q.orient;
          status_q <= kbi_pkg::STAT_BEFORE;
        end else begin
          res_a_q  <= rd_data_q.pos_a;
          res_b_q  <= rd_data_q.pos_b;
          res_o_q  <= rd_data_q.orient;
          status_q <= kbi_pkg::STAT_AFTER;
        end
      end
      S_SEARCH: begin
        if (advance) begin
          lo_q  <= rd_data_q;
          idx_q <= idx_q + AW'(1);
        end else begin
          hi_q <= rd_data_q;
          dz_q <= div_den == 32'd0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          alpha_q <= dz_q ? '0 : div_quot[F:0];
        end
      end
      S_MUL: begin
        prod_q <= prod;
        case (step_q)
          3'd1: sq_q <= shr[F:0];
          3'd2: begin
            // Smooth weight 3a^2 - 2a^3, held to [0, 1].
            if (w_raw < 0) begin
              wo_q <= '0;
            end else if (w_raw > $signed(WW'(1) << F)) begin
              wo_q <= (F+1)'(1) << F;
            end else begin
              wo_q <= w_raw[F:0];
            end
          end
          3'd4: res_a_q <= lo_q.pos_a + shr[31:0];
          3'd5: res_b_q <= lo_q.pos_b + shr[31:0];
          3'd6: begin
            res_o_q  <= lo_q.orient + shr[31:0];
            status_q <= kbi_pkg::STAT_INTERP;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      pos_a_q  <= res_a_q;
      pos_b_q  <= res_b_q;
      orient_q <= res_o_q;
      clamp_q  <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_a_o        = pos_a_q;
  assign pos_b_o        = pos_b_q;
  assign orientation_o  = orient_q;
  assign clamp_status_o = clamp_q;

  a_query_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == kbi_pkg::OP_QUERY |=> in_stall_o)
    else $error("query request did not start a search");

  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == kbi_pkg::OP_WRITE |=> !in_stall_o)
    else $error("write request held the input channel");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> idx_q <= last_q)
    else $error("key scan ran past the last key");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_a_o))
    else $error("stalled result was overwritten");

endmodule
